>>> hw/rtl/rlc_pkg.sv
// Shared types and constants for the bitmap run-length codec.
package rlc_pkg;

    // Codeword length field L; L never exceeds 32.
    localparam int LEN_W = 6;
    // Decode header saturates at this many ones.
    localparam logic [LEN_W-1:0] HDR_MAX = 6'd63;

    // Result queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    // Codec modes.
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Control flags that travel with each queued result.
    typedef struct packed {
        logic is_dec;   // decoded run, not a codeword
        logic dual;     // follow with an empty-run codeword marked last
        logic trail;    // decoded run followed by a one
        logic ovf;      // run count saturated
        logic last;     // final result of the stream
    } rlc_flags_t;

endpackage

>>> hw/rtl/rlc_front.sv
// Front end: mode register, run counting and codeword parsing per input bit.
module rlc_front
    import rlc_pkg::*;
#(
    parameter int RUN_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                take,
    input  logic                in_bit,
    input  logic                eos,
    output logic                push,
    output logic [RUN_BITS-1:0] push_value,
    output logic [LEN_W-1:0]    push_len,
    output rlc_flags_t          push_flags
);

    logic                mode_reg;
    logic [RUN_BITS-1:0] zero_run_reg, zero_run_next;
    logic [LEN_W-1:0]    run_len_reg, run_len_next;
    logic [RUN_BITS:0]   pow_reg, pow_next;
    logic                ovf_reg, ovf_next;
    logic                phase_reg, phase_next;
    logic [LEN_W-1:0]    hdr_reg, hdr_next;
    logic [LEN_W-1:0]    left_reg, left_next;
    logic [RUN_BITS-1:0] body_reg, body_next;
    logic [RUN_BITS:0]   run_inc;

    localparam logic [LEN_W-1:0]  LEN_ONE = LEN_W'(1);
    localparam logic [RUN_BITS:0] POW_TWO = (RUN_BITS+1)'(2);

    assign run_inc = {1'b0, zero_run_reg} + (RUN_BITS+1)'(1);

    always_comb
    begin
        zero_run_next = zero_run_reg;
        run_len_next  = run_len_reg;
        pow_next      = pow_reg;
        ovf_next      = ovf_reg;
        phase_next    = phase_reg;
        hdr_next      = hdr_reg;
        left_next     = left_reg;
        body_next     = body_reg;
        push          = 1'b0;
        push_value    = zero_run_reg;
        push_len      = run_len_reg;
        push_flags    = '0;
        if (take)
        begin
            if (mode_reg == MODE_ENCODE)
            begin
                if (!in_bit)
                begin
                    // Count the zero; saturate at the counter limit.
                    if (&zero_run_reg)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        zero_run_next = run_inc[RUN_BITS-1:0];
                        if (run_inc == pow_reg)
                        begin
                            run_len_next = run_len_reg + LEN_ONE;
                            pow_next     = pow_reg << 1;
                        end
                    end
                    if (eos)
                    begin
                        push            = 1'b1;
                        push_value      = zero_run_next;
                        push_len        = run_len_next;
                        push_flags.ovf  = ovf_next;
                        push_flags.last = 1'b1;
                    end
                end
                else
                begin
                    // A one closes the run; at end of stream an empty run follows.
                    push            = 1'b1;
                    push_flags.ovf  = ovf_reg;
                    push_flags.dual = eos;
                    zero_run_next   = '0;
                    run_len_next    = LEN_ONE;
                    pow_next        = POW_TWO;
                    ovf_next        = 1'b0;
                end
            end
            else
            begin
                push_flags.is_dec = 1'b1;
                if (!phase_reg)
                begin
                    if (in_bit)
                    begin
                        if (hdr_reg < HDR_MAX)
                        begin
                            hdr_next = hdr_reg + LEN_ONE;
                        end
                    end
                    else
                    begin
                        phase_next = 1'b1;
                        left_next  = hdr_reg;
                        body_next  = '0;
                    end
                end
                else
                begin
                    if (body_reg[RUN_BITS-1])
                    begin
                        body_next = '1;
                        ovf_next  = 1'b1;
                    end
                    else
                    begin
                        body_next = RUN_BITS'({body_reg, in_bit});
                    end
                    if (left_reg == '0)
                    begin
                        push             = 1'b1;
                        push_value       = body_next;
                        push_len         = '0;
                        push_flags.trail = !eos;
                        push_flags.ovf   = ovf_next;
                        push_flags.last  = eos;
                        phase_next       = 1'b0;
                        hdr_next         = '0;
                        body_next        = '0;
                        ovf_next         = 1'b0;
                    end
                    else
                    begin
                        left_next = left_reg - LEN_ONE;
                    end
                end
            end
            // End of stream drops any partial state.
            if (eos)
            begin
                zero_run_next = '0;
                run_len_next  = LEN_ONE;
                pow_next      = POW_TWO;
                ovf_next      = 1'b0;
                phase_next    = 1'b0;
                hdr_next      = '0;
                left_next     = '0;
                body_next     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_ENCODE;
            zero_run_reg <= '0;
            run_len_reg  <= LEN_ONE;
            pow_reg      <= POW_TWO;
            ovf_reg      <= 1'b0;
            phase_reg    <= 1'b0;
            hdr_reg      <= '0;
            left_reg     <= '0;
            body_reg     <= '0;
        end
        else if (cfg_wr_en)
        begin
            mode_reg     <= cfg_wr_data;
            zero_run_reg <= '0;
            run_len_reg  <= LEN_ONE;
            pow_reg      <= POW_TWO;
            ovf_reg      <= 1'b0;
            phase_reg    <= 1'b0;
            hdr_reg      <= '0;
            left_reg     <= '0;
            body_reg     <= '0;
        end
        else
        begin
            zero_run_reg <= zero_run_next;
            run_len_reg  <= run_len_next;
            pow_reg      <= pow_next;
            ovf_reg      <= ovf_next;
            phase_reg    <= phase_next;
            hdr_reg      <= hdr_next;
            left_reg     <= left_next;
            body_reg     <= body_next;
        end
    end

endmodule

>>> hw/rtl/rlc_queue.sv
// Small FIFO of pending results between the front and back ends.
module rlc_queue
    import rlc_pkg::*;
#(
    parameter int RUN_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [RUN_BITS-1:0] push_value,
    input  logic [LEN_W-1:0]    push_len,
    input  rlc_flags_t          push_flags,
    input  logic                pop,
    output logic                head_valid,
    output logic [RUN_BITS-1:0] head_value,
    output logic [LEN_W-1:0]    head_len,
    output rlc_flags_t          head_flags,
    output logic [Q_CW-1:0]     fill
);

    logic [RUN_BITS-1:0] value_mem [Q_DEPTH];
    logic [LEN_W-1:0]    len_mem   [Q_DEPTH];
    rlc_flags_t          flags_mem [Q_DEPTH];
    logic [Q_AW-1:0]     wr_ptr_reg;
    logic [Q_AW-1:0]     rd_ptr_reg;
    logic [Q_CW-1:0]     count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign head_value = value_mem[rd_ptr_reg];
    assign head_len   = len_mem[rd_ptr_reg];
    assign head_flags = flags_mem[rd_ptr_reg];
    assign fill       = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + Q_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            value_mem[wr_ptr_reg] <= push_value;
            len_mem[wr_ptr_reg]   <= push_len;
            flags_mem[wr_ptr_reg] <= push_flags;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> hw/rtl/rlc_back.sv
// Back end: builds codewords or run results and holds them in the output register.
module rlc_back
    import rlc_pkg::*;
#(
    parameter int RUN_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  logic [RUN_BITS-1:0] head_value,
    input  logic [LEN_W-1:0]    head_len,
    input  rlc_flags_t          head_flags,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [63:0]         out_word,
    output logic [6:0]          out_length,
    output logic                out_trail,
    output logic                out_ovf,
    output logic                out_last
);

    logic        valid_reg;
    logic        sec_reg;
    logic [63:0] word_reg;
    logic [6:0]  length_reg;
    logic        trail_reg, ovf_reg, last_reg;

    logic        load;
    logic [LEN_W-1:0] src_len;
    logic [63:0] src_count;
    logic [63:0] hdr_mask;
    logic [63:0] word_next;
    logic [6:0]  length_next;
    logic        trail_next, ovf_next, last_next;

    assign load = !valid_reg || out_ready;
    assign pop  = head_valid && load && (sec_reg || !head_flags.dual);

    always_comb
    begin
        // Second result of a dual entry is the empty-run codeword "00".
        if (sec_reg)
        begin
            src_len   = LEN_W'(1);
            src_count = '0;
        end
        else
        begin
            src_len   = head_len;
            src_count = 64'(head_value);
        end
        // Header ones sit above a zero at bit L, below bit 2L.
        for (int i = 0; i < 64; i++)
        begin
            hdr_mask[i] = (7'(i) > {1'b0, src_len}) && (7'(i) < {src_len, 1'b0});
        end
        if (!sec_reg && head_flags.is_dec)
        begin
            word_next   = src_count;
            length_next = '0;
            trail_next  = head_flags.trail;
            ovf_next    = head_flags.ovf;
            last_next   = head_flags.last;
        end
        else if (sec_reg)
        begin
            word_next   = hdr_mask | src_count;
            length_next = {src_len, 1'b0};
            trail_next  = 1'b0;
            ovf_next    = 1'b0;
            last_next   = 1'b1;
        end
        else
        begin
            word_next   = hdr_mask | src_count;
            length_next = {src_len, 1'b0};
            trail_next  = 1'b0;
            ovf_next    = head_flags.ovf;
            last_next   = head_flags.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && head_valid)
        begin
            word_reg   <= word_next;
            length_reg <= length_next;
            trail_reg  <= trail_next;
            ovf_reg    <= ovf_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sec_reg   <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= head_valid;
            if (head_valid)
            begin
                sec_reg <= !sec_reg && head_flags.dual;
            end
        end
    end

    assign out_valid  = valid_reg;
    assign out_word   = word_reg;
    assign out_length = length_reg;
    assign out_trail  = trail_reg;
    assign out_ovf    = ovf_reg;
    assign out_last   = last_reg;

endmodule

>>> hw/rtl/bitmap_run_length_codec_core.sv
// Path: a result goes from its transfer into the queue, then into the output register.
// Throughput: one input transfer per cycle while the four-entry result queue has room;
//   one result per ready output cycle; an encode stream ending in a one gives two results.
// The queue fill sets the input side: s_axis_tready drops only while the queue is full.
// Reset (rst_n low, asynchronous): encode mode, all run and parse state cleared, queue empty.
// Writing codec_mode clears all run and parse state as well.
module bitmap_run_length_codec_core
    import rlc_pkg::*;
#(
    parameter int RUN_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: codec_mode (0 encode, 1 decode)
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] in_bit, [7:1] zero
    input  logic        s_axis_tlast,   // end_of_stream
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [63:0] code_word, [70:64] code_length, [71] zero
    output logic [1:0]  m_axis_tuser,   // [0] trailing_one, [1] overflow
    output logic        m_axis_tlast    // last_result
);

    logic                take;
    logic                push;
    logic [RUN_BITS-1:0] push_value;
    logic [LEN_W-1:0]    push_len;
    rlc_flags_t          push_flags;
    logic                pop;
    logic                head_valid;
    logic [RUN_BITS-1:0] head_value;
    logic [LEN_W-1:0]    head_len;
    rlc_flags_t          head_flags;
    logic [Q_CW-1:0]     fill;
    logic [63:0]         out_word;
    logic [6:0]          out_length;
    logic                out_trail;
    logic                out_ovf;

    // Accept a bit whenever the queue has a free slot, even if the output stalls.
    assign s_axis_tready = (fill != Q_CW'(Q_DEPTH));
    assign take          = s_axis_tvalid && s_axis_tready;

    rlc_front #(
        .RUN_BITS (RUN_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .take        (take),
        .in_bit      (s_axis_tdata[0]),
        .eos         (s_axis_tlast),
        .push        (push),
        .push_value  (push_value),
        .push_len    (push_len),
        .push_flags  (push_flags)
    );

    // Decouple parsing from output backpressure.
    rlc_queue #(
        .RUN_BITS (RUN_BITS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_value (push_value),
        .push_len   (push_len),
        .push_flags (push_flags),
        .pop        (pop),
        .head_valid (head_valid),
        .head_value (head_value),
        .head_len   (head_len),
        .head_flags (head_flags),
        .fill       (fill)
    );

    // Build the result and hold it until the sink takes the transfer.
    rlc_back #(
        .RUN_BITS (RUN_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_value (head_value),
        .head_len   (head_len),
        .head_flags (head_flags),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_word   (out_word),
        .out_length (out_length),
        .out_trail  (out_trail),
        .out_ovf    (out_ovf),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_length, out_word};
    assign m_axis_tuser = {out_ovf, out_trail};

`ifndef SYNTHESIS
    // Input side stalls only because the queue is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (fill == Q_CW'(Q_DEPTH)))
        else $error("input stalled with room in the result queue");

    // A decoded run that ends the stream is never followed by a one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> !m_axis_tuser[0])
        else $error("final result flags a trailing one");

    // Codeword lengths are always even.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[64])
        else $error("odd codeword length");
`endif

endmodule
